### hdl/sda_pkg.sv
`default_nettype none
package sda_pkg;

  // Raster size and the texel address width that goes with it.
  localparam int MAX_TEXELS = 4096;
  localparam int TEXEL_AW   = 12;

  typedef enum logic [2:0] {
    ST_APPLIED  = 3'd0,
    ST_DUP      = 3'd1,
    ST_PAST     = 3'd2,
    ST_GAP      = 3'd3,
    ST_COV_BAD  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_MODE        = 2'd0,
    REG_TEXEL_COUNT = 2'd1,
    REG_STAMP_COUNT = 2'd2
  } reg_idx_e;

  // Control that travels down the pipeline with each item.
  typedef struct packed {
    logic        apply;
    logic [2:0]  status;
    logic        done;
    logic [15:0] applied;
    logic        mode;
  } ctl_t;

endpackage
`default_nettype wire

### hdl/stamp_deposition_accumulator.sv
`default_nettype none
// Channel | direction | handshake       | payload
// in      | input     | valid / stall   | ordinal, opacity, flow, coverage
// out     | output    | valid / stall   | status, index, level, strength, done, count
// cfg     | input     | valid / ready   | index, data
// One item per cycle while no stall holds it, through three register stages (check +
// first product, level update, strength update into the result register); a result
// is presented once its item has passed all three. After reset a clearing pass
// over all 4096 texels zeroes both stores and in_stall_o stays high meanwhile.
// A waiting result freezes the whole pipeline and stalls the input in the
// same cycle; repeated hits on one texel are forwarded from the write stages.
module stamp_deposition_accumulator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] stamp_ordinal_i,
  input  wire logic [15:0] stamp_opacity_i,
  input  wire logic [15:0] stamp_flow_i,
  input  wire logic [15:0] coverage_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [11:0]      texel_index_o,
  output logic [15:0]      level_o,
  output logic [15:0]      strength_o,
  output logic             stamp_done_o,
  output logic [15:0]      applied_stamps_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW = sda_pkg::TEXEL_AW;

  logic        mode_q;
  logic [12:0] tc_q;
  logic [15:0] sc_q;
  logic [13:0] tc_eff;
  logic        clr_q;
  logic [AW-1:0] clr_addr_q;
  logic        adv, in_fire;
  logic        v1_q, v2_q, v3_q;
  logic [AW-1:0] pos, pos1_q, pos2_q;
  sda_pkg::ctl_t ctl, ctl1_q, ctl2_q;
  logic [15:0] lvl_mem [sda_pkg::MAX_TEXELS];
  logic [15:0] str_mem [sda_pkg::MAX_TEXELS];
  logic [15:0] rd_lvl_q, rd_str_q, old_lvl, old_str;
  logic        lfwd_q, sfwd_q;
  logic [15:0] lvl_hold_q, str_hold_q, lvl2_q;
  logic [15:0] new_lvl, new_str, fin_lvl, fin_str;
  logic        lvl_wr, str_wr;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      tc_q   <= 13'd1;
      sc_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sda_pkg::REG_MODE:        mode_q <= cfg_data_i[0];
        sda_pkg::REG_TEXEL_COUNT: tc_q   <= cfg_data_i[12:0];
        sda_pkg::REG_STAMP_COUNT: sc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tc_q == 13'd0) tc_eff = 14'd1;
    else if (14'(tc_q) > 14'(sda_pkg::MAX_TEXELS)) tc_eff = 14'(sda_pkg::MAX_TEXELS);
    else tc_eff = 14'(tc_q);
  end

  // Clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(sda_pkg::MAX_TEXELS - 1)) clr_q <= 1'b0;
    end
  end

  assign adv        = !(out_valid_o && out_stall_i) && !clr_q;
  assign in_stall_o = !adv;
  assign in_fire    = in_valid_i && adv;

  sda_front #(.AW(AW)) u_front (
    .clk_i, .rst_ni, .adv_i(in_fire), .in_fire_i(in_fire),
    .ordinal_i(stamp_ordinal_i), .coverage_i(coverage_i), .mode_i(mode_q),
    .tc_i(tc_eff), .stamp_count_i(sc_q), .pos_o(pos), .ctl_o(ctl)
  );

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage registers: level read into stage two, strength read into stage three.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos1_q     <= pos;
      ctl1_q     <= ctl;
      rd_lvl_q   <= lvl_mem[pos];
      lfwd_q     <= lvl_wr && (pos1_q == pos);
      lvl_hold_q <= new_lvl;
      pos2_q     <= pos1_q;
      ctl2_q     <= ctl1_q;
      lvl2_q     <= fin_lvl;
      rd_str_q   <= str_mem[pos1_q];
      sfwd_q     <= str_wr && (pos2_q == pos1_q);
      str_hold_q <= new_str;
    end
  end

  assign old_lvl = lfwd_q ? lvl_hold_q : rd_lvl_q;
  assign old_str = sfwd_q ? str_hold_q : rd_str_q;

  sda_math u_math (
    .clk_i, .adv_i(adv), .mode_i(ctl.mode),
    .op_i(stamp_opacity_i > 16'd32768 ? 16'd32768 : stamp_opacity_i),
    .flow_i(stamp_flow_i > 16'd32768 ? 16'd32768 : stamp_flow_i),
    .cov_i(coverage_i), .mode_s1_i(ctl1_q.mode), .old_lvl_i(old_lvl),
    .lvl_o(new_lvl), .mode_s2_i(ctl2_q.mode), .lvl_s2_i(lvl2_q),
    .old_str_i(old_str), .str_o(new_str)
  );

  // Write stages: stores updated by applied items, cleared after reset.
  assign lvl_wr  = adv && v1_q && ctl1_q.apply;
  assign str_wr  = adv && v2_q && ctl2_q.apply;
  assign fin_lvl = ctl1_q.apply ? new_lvl : old_lvl;
  assign fin_str = ctl2_q.apply ? new_str : old_str;
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      lvl_mem[clr_addr_q] <= '0;
    end else if (lvl_wr) begin
      lvl_mem[pos1_q] <= new_lvl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      str_mem[clr_addr_q] <= '0;
    end else if (str_wr) begin
      str_mem[pos2_q] <= new_str;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_o         <= ctl2_q.status;
      texel_index_o    <= 12'(pos2_q);
      level_o          <= lvl2_q;
      strength_o       <= fin_str;
      stamp_done_o     <= ctl2_q.done;
      applied_stamps_o <= ctl2_q.applied;
    end
  end
  assign out_valid_o = v3_q;

  a_clr_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !v1_q) else $error("item entered during clear");
  a_done_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ctl1_q.done) |-> ctl1_q.apply) else $error("done without apply");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(level_o)) else $error("output moved");

endmodule
`default_nettype wire

### hdl/sda_front.sv
`default_nettype none
// Front end: checks each item against the stroke state and picks its texel.
module sda_front #(
  parameter int AW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          in_fire_i,
  input  wire logic [15:0]   ordinal_i,
  input  wire logic [15:0]   coverage_i,
  input  wire logic          mode_i,
  input  wire logic [13:0]   tc_i,
  input  wire logic [15:0]   stamp_count_i,
  output logic [AW-1:0]      pos_o,
  output sda_pkg::ctl_t      ctl_o
);

  logic [AW-1:0] pos_q, pos_d;
  logic [15:0]   nord_q, nord_d, cnt_q, cnt_d;
  logic [AW-1:0] pos_eff;
  logic [13:0]   pos_ext;

  always_comb begin
    pos_ext = 14'(pos_q);
    pos_eff = (pos_ext >= tc_i) ? '0 : pos_q;
    if (ordinal_i >= stamp_count_i)           ctl_o.status = sda_pkg::ST_PAST;
    else if (coverage_i > 16'd32768)          ctl_o.status = sda_pkg::ST_COV_BAD;
    else if (ordinal_i < nord_q)              ctl_o.status = sda_pkg::ST_DUP;
    else if (ordinal_i != nord_q)             ctl_o.status = sda_pkg::ST_GAP;
    else                                      ctl_o.status = sda_pkg::ST_APPLIED;
    ctl_o.apply = (ctl_o.status == sda_pkg::ST_APPLIED);
    ctl_o.done  = ctl_o.apply && (14'(pos_eff) + 14'd1 >= tc_i);
    ctl_o.mode  = mode_i;
    pos_d  = pos_q;
    nord_d = nord_q;
    cnt_d  = cnt_q;
    if (in_fire_i && ctl_o.apply) begin
      if (ctl_o.done) begin
        pos_d  = '0;
        nord_d = nord_q + 16'd1;
        cnt_d  = cnt_q + 16'd1;
      end else begin
        pos_d = pos_eff + AW'(1);
      end
    end
    ctl_o.applied = cnt_d;
    pos_o = pos_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nord_q <= '0;
      cnt_q  <= '0;
    end else if (adv_i) begin
      pos_q  <= pos_d;
      nord_q <= nord_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### hdl/sda_math.sv
`default_nettype none
// Level and strength arithmetic, one multiplier level per stage.
// Stage one forms op*flow or flow*cov, stage two the new level and
// stage three the strength candidate and its maximum.
module sda_math (
  input  wire logic        clk_i,
  input  wire logic        adv_i,
  input  wire logic        mode_i,
  input  wire logic [15:0] op_i,
  input  wire logic [15:0] flow_i,
  input  wire logic [15:0] cov_i,
  input  wire logic        mode_s1_i,
  input  wire logic [15:0] old_lvl_i,
  output logic [15:0]      lvl_o,
  input  wire logic        mode_s2_i,
  input  wire logic [15:0] lvl_s2_i,
  input  wire logic [15:0] old_str_i,
  output logic [15:0]      str_o
);

  logic [31:0] p1;
  logic [15:0] p1_q, cov_q, op_q;
  logic [15:0] p1_s2_q, cov_s2_q, op_s2_q;
  logic [16:0] one_m_lvl, one_m_fc;
  logic [33:0] p2;
  logic [31:0] p3;
  logic [15:0] cand;

  // First product, registered with the operands needed later.
  assign p1 = mode_i ? flow_i * cov_i : op_i * flow_i;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_q     <= p1[30:15];
      cov_q    <= cov_i;
      op_q     <= op_i;
      p1_s2_q  <= p1_q;
      cov_s2_q <= cov_q;
      op_s2_q  <= op_q;
    end
  end

  // Second stage forms the new level from the stored one.
  always_comb begin
    one_m_lvl = 17'd32768 - 17'(old_lvl_i);
    one_m_fc  = 17'd32768 - 17'(p1_q);
    p2        = one_m_lvl * one_m_fc;
    if (mode_s1_i) begin
      lvl_o = 16'(17'd32768 - p2[31:15]);
    end else begin
      lvl_o = (cov_q > old_lvl_i) ? cov_q : old_lvl_i;
    end
  end

  // Third stage forms the strength candidate and keeps the maximum.
  always_comb begin
    if (mode_s2_i) begin
      p3 = op_s2_q * lvl_s2_i;
    end else begin
      p3 = p1_s2_q * cov_s2_q;
    end
    cand  = p3[30:15];
    str_o = (cand > old_str_i) ? cand : old_str_i;
  end

endmodule
`default_nettype wire

### tb/tb_stamp_deposition_accumulator.sv
`default_nettype none
module tb_stamp_deposition_accumulator;

  localparam int TEXELS = 4096;
  localparam int ONE = 32768;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    sda_pkg::status_e status;
    logic [11:0] index;
    logic [15:0] level;
    logic [15:0] strength;
    logic        done;
    logic [15:0] applied;
  } deposit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] stamp_ordinal_i = '0;
  logic [15:0] stamp_opacity_i = '0;
  logic [15:0] stamp_flow_i = '0;
  logic [15:0] coverage_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [11:0] texel_index_o;
  logic [15:0] level_o;
  logic [15:0] strength_o;
  logic        stamp_done_o;
  logic [15:0] applied_stamps_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  stamp_deposition_accumulator i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the raster and the stroke bookkeeping.
  logic [15:0] level_mem [TEXELS];
  logic [15:0] strength_mem [TEXELS];
  logic [15:0] next_ord;
  logic [11:0] cur_pos;
  logic [15:0] applied_cnt;
  logic        mode_q;
  logic [12:0] texel_count_q;
  logic [15:0] stamp_count_q;

  deposit_t expected_q[$];
  int       error_cnt = 0;
  int       burst_left = 0;
  int       hold_request = 0;

  // Compute the result of one texel coverage and update the shadow raster.
  function automatic deposit_t deposit(logic [15:0] ord, logic [15:0] op_in,
                                       logic [15:0] flow_in, logic [15:0] cov);
    deposit_t r;
    int unsigned op, flow, tc, pos, lvl, str, cand, fc;
    op = 32'(op_in);
    if (op > ONE) op = ONE;
    flow = 32'(flow_in);
    if (flow > ONE) flow = ONE;
    tc = 32'(texel_count_q);
    if (tc == 0) tc = 1;
    if (tc > TEXELS) tc = TEXELS;
    pos = 32'(cur_pos);
    if (pos >= tc) pos = 0;
    if (ord >= stamp_count_q) r.status = sda_pkg::ST_PAST;
    else if (cov > ONE) r.status = sda_pkg::ST_COV_BAD;
    else if (ord < next_ord) r.status = sda_pkg::ST_DUP;
    else if (ord != next_ord) r.status = sda_pkg::ST_GAP;
    else r.status = sda_pkg::ST_APPLIED;
    r.done = 1'b0;
    if (r.status == sda_pkg::ST_APPLIED) begin
      lvl = 32'(level_mem[pos]);
      str = 32'(strength_mem[pos]);
      if (!mode_q) begin
        if (cov > lvl) lvl = 32'(cov);
        cand = (((op * flow) >> 15) * 32'(cov)) >> 15;
      end else begin
        fc = (flow * 32'(cov)) >> 15;
        lvl = ONE - (((ONE - lvl) * (ONE - fc)) >> 15);
        cand = (op * lvl) >> 15;
      end
      if (cand > str) str = cand;
      level_mem[pos] = lvl[15:0];
      strength_mem[pos] = str[15:0];
      if (pos + 1 >= tc) begin
        r.done = 1'b1;
        cur_pos = '0;
        next_ord = next_ord + 16'd1;
        applied_cnt = applied_cnt + 16'd1;
      end else begin
        cur_pos = 12'(pos + 1);
      end
    end
    r.index = pos[11:0];
    r.level = level_mem[pos];
    r.strength = strength_mem[pos];
    r.applied = applied_cnt;
    return r;
  endfunction

  // Offer one texel coverage; the sender runs in bursts with random gaps.
  task automatic send_texel(logic [15:0] ord, logic [15:0] op, logic [15:0] flow,
                            logic [15:0] cov);
    int gap;
    deposit_t pred;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    stamp_ordinal_i <= ord;
    stamp_opacity_i <= op;
    stamp_flow_i <= flow;
    coverage_i <= cov;
    do @(posedge clk_i); while (in_stall_o);
    pred = deposit(ord, op, flow, cov);
    expected_q = {expected_q, pred};
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write, only ever issued with the pipeline empty.
  task automatic write_reg(sda_pkg::reg_idx_e idx, logic [15:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sda_pkg::REG_MODE:        mode_q = data[0];
      sda_pkg::REG_TEXEL_COUNT: texel_count_q = data[12:0];
      sda_pkg::REG_STAMP_COUNT: stamp_count_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_cov();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, ONE));
  endfunction

  // Receiver stalls: a long hold when asked, otherwise a changing duty pattern.
  initial begin
    int hold_cnt, pattern;
    hold_cnt = 0;
    pattern = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_cnt = hold_request;
        hold_request = 0;
      end
      if ($urandom_range(0, 63) == 0) pattern = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        case (pattern)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    deposit_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no prediction pending");
        error_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          error_cnt++;
        end
        if (texel_index_o !== e.index) begin
          $error("texel_index expected %0d actual %0d", e.index, texel_index_o);
          error_cnt++;
        end
        if (level_o !== e.level) begin
          $error("level expected %0d actual %0d", e.level, level_o);
          error_cnt++;
        end
        if (strength_o !== e.strength) begin
          $error("strength expected %0d actual %0d", e.strength, strength_o);
          error_cnt++;
        end
        if (stamp_done_o !== e.done) begin
          $error("stamp_done expected %0d actual %0d", e.done, stamp_done_o);
          error_cnt++;
        end
        if (applied_stamps_o !== e.applied) begin
          $error("applied_stamps expected %0d actual %0d", e.applied, applied_stamps_o);
          error_cnt++;
        end
      end
    end
  end

  // With the reset stroke length of zero every ordinal is past the stroke.
  task automatic test_reset_state;
    send_texel(16'd0, 16'd0, 16'd0, 16'd0);
    send_texel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_texel(16'd1, 16'd32768, 16'd32768, 16'd32768);
  endtask

  // Non-building mode: extremes, every rejection and saturated controls.
  task automatic test_max_mode;
    write_reg(sda_pkg::REG_MODE, 16'd0);
    write_reg(sda_pkg::REG_TEXEL_COUNT, 16'd3);
    write_reg(sda_pkg::REG_STAMP_COUNT, 16'd4);
    send_texel(16'd0, 16'd32768, 16'd32768, 16'd32768);
    send_texel(16'd0, 16'hFFFF, 16'hFFFF, 16'd16384);
    send_texel(16'd0, 16'd1000, 16'd20000, 16'd0);
    send_texel(16'd0, 16'd32768, 16'd32768, 16'd100);
    send_texel(16'd2, 16'd32768, 16'd32768, 16'd100);
    send_texel(16'd4, 16'd32768, 16'd32768, 16'd100);
    send_texel(16'd1, 16'd32768, 16'd32768, 16'd32769);
    send_texel(16'd1, 16'd12345, 16'd23456, 16'd30000);
    send_texel(16'd1, 16'd32768, 16'd40000, 16'd32000);
    send_texel(16'd1, 16'd0, 16'd0, 16'd1);
  endtask

  // Build-up mode compounding, then odd raster sizes.
  task automatic test_buildup_mode;
    write_reg(sda_pkg::REG_MODE, 16'd1);
    send_texel(16'd2, 16'd32768, 16'd32768, 16'd16384);
    send_texel(16'd2, 16'd30000, 16'd16384, 16'd32768);
    send_texel(16'd2, 16'd32768, 16'd32768, 16'd32768);
    send_texel(16'd3, 16'hFFFF, 16'hFFFF, 16'd32768);
    send_texel(16'd3, 16'd20000, 16'd20000, 16'd20000);
    // A raster shrunk below the current position restarts at texel zero.
    write_reg(sda_pkg::REG_TEXEL_COUNT, 16'd1);
    send_texel(16'd3, 16'd32768, 16'd8000, 16'd9000);
    write_reg(sda_pkg::REG_TEXEL_COUNT, 16'd0);
    write_reg(sda_pkg::REG_STAMP_COUNT, 16'd6);
    send_texel(16'd4, 16'd16384, 16'd16384, 16'd16384);
    send_texel(16'd5, 16'd16384, 16'd16384, 16'd16384);
  endtask

  // Large raster, with an out-of-range count clamped to the maximum.
  task automatic test_full_raster;
    write_reg(sda_pkg::REG_TEXEL_COUNT, 16'd8191);
    write_reg(sda_pkg::REG_STAMP_COUNT, 16'hFFFF);
    for (int i = 0; i < 300; i++)
      send_texel(next_ord, 16'($urandom()), 16'($urandom()), 16'($urandom_range(0, ONE)));
    write_reg(sda_pkg::REG_TEXEL_COUNT, 16'd4096);
    send_texel(next_ord, 16'd32768, 16'd32768, 16'd32768);
  endtask

  // Random strokes: mostly well-formed stamps, some noise items.
  task automatic test_random_strokes(int items);
    int n;
    logic [15:0] ord;
    n = 0;
    while (n < items) begin
      write_reg(sda_pkg::REG_MODE, 16'($urandom_range(0, 1)));
      write_reg(sda_pkg::REG_TEXEL_COUNT, ($urandom_range(0, 7) == 0) ?
                16'($urandom_range(0, 64)) : 16'($urandom_range(1, 8)));
      write_reg(sda_pkg::REG_STAMP_COUNT, ($urandom_range(0, 5) == 0) ? 16'hFFFF :
                16'(next_ord + $urandom_range(0, 12)));
      for (int k = 0; k < 60 && n < items; k++, n++) begin
        case ($urandom_range(0, 9))
          0:       ord = 16'($urandom());
          1:       ord = next_ord - 16'($urandom_range(1, 3));
          2:       ord = next_ord + 16'($urandom_range(1, 3));
          default: ord = next_ord;
        endcase
        send_texel(ord, 16'($urandom()), ($urandom_range(0, 3) == 0) ?
                   16'($urandom()) : 16'($urandom_range(0, ONE)), rand_cov());
      end
    end
  endtask

  // Hold the output off long enough to back the pipeline up into the input.
  task automatic test_backpressure;
    write_reg(sda_pkg::REG_TEXEL_COUNT, 16'd5);
    write_reg(sda_pkg::REG_STAMP_COUNT, 16'(next_ord + 20));
    hold_request = 200;
    for (int i = 0; i < 60; i++)
      send_texel(next_ord, 16'($urandom()), 16'($urandom()), rand_cov());
    drain();
    for (int i = 0; i < 20; i++)
      send_texel(next_ord, 16'($urandom()), 16'($urandom()), rand_cov());
  endtask

  initial begin
    for (int i = 0; i < TEXELS; i++) begin
      level_mem[i] = '0;
      strength_mem[i] = '0;
    end
    next_ord = '0;
    cur_pos = '0;
    applied_cnt = '0;
    mode_q = 1'b0;
    texel_count_q = 13'd1;
    stamp_count_q = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_max_mode();
    test_buildup_mode();
    test_full_raster();
    test_random_strokes(780);
    test_backpressure();
    drain();
    if (error_cnt == 0) $display("stamp_deposition_accumulator verification clean");
    else $display("stamp_deposition_accumulator verification failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 1000000);
    $display("stamp_deposition_accumulator verification failed");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/sda_pkg.sv
hdl/sda_front.sv
hdl/sda_math.sv
hdl/stamp_deposition_accumulator.sv
tb/tb_stamp_deposition_accumulator.sv
